// File: rtl/tiny_register_machine_execute_macros.svh
// Assertion macros shared by the execute block.
`ifndef TINY_REGISTER_MACHINE_EXECUTE_MACROS_SVH
`define TINY_REGISTER_MACHINE_EXECUTE_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define TRME_CHECK(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define TRME_IMPLIES(label, ante, cons, msg) \
	`TRME_CHECK(label, (!(ante)) || (cons), msg)

`endif

// File: rtl/trme_pkg.sv
// Constants and types of the tiny register machine execute block.
package trme_pkg;

	localparam int NUM_REGS    = 5;
	localparam int DATA_WIDTH  = 32;
	localparam int PROG_MAX    = 256;
	localparam int PC_W        = 9;
	localparam int FUNC_W      = 3;
	localparam int REG_IDX_W   = 3;
	localparam int RF_AW       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int CNT_W       = RF_AW;
	localparam int CONST_INDEX = NUM_REGS;

	typedef enum logic [FUNC_W-1:0] {
		FN_MOV = 3'd0,
		FN_ADD = 3'd1,
		FN_SUB = 3'd2,
		FN_JMP = 3'd3,
		FN_PRN = 3'd4,
		FN_HLT = 3'd5
	} func_t;

endpackage

// File: rtl/trme_intf.sv
// Request channels of the execute block: instructions, results and configuration.
interface trme_in_if import trme_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [FUNC_W-1:0]            func;
	logic [REG_IDX_W-1:0]         first_reg;
	logic                         src_is_reg;
	logic [REG_IDX_W-1:0]         source_reg;
	logic signed [DATA_WIDTH-1:0] immediate;

	modport source (output valid, func, first_reg, src_is_reg, source_reg, immediate,
		input ready);
	modport sink (input valid, func, first_reg, src_is_reg, source_reg, immediate,
		output ready);
endinterface

interface trme_out_if import trme_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [PC_W-1:0]              next_pc;
	logic                         value_valid;
	logic signed [DATA_WIDTH-1:0] value;
	logic [REG_IDX_W-1:0]         value_index;
	logic                         is_halted;
	logic                         status;
	logic                         last;

	modport source (output valid, next_pc, value_valid, value, value_index, is_halted,
		status, last, input ready);
	modport sink (input valid, next_pc, value_valid, value, value_index, is_halted,
		status, last, output ready);
endinterface

interface trme_cfg_if import trme_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [PC_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: rtl/trme_ram.sv
// Generic RAM with one write port and two registered read ports.
module trme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 5
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                         rdata_a,
	output logic [WIDTH-1:0]                         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port; reads return the contents before a write at the same edge.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: rtl/tiny_register_machine_execute.sv
// Top level of the tiny register machine execute block.
//
// Instruction requests arrive on instr, results leave on result, and the
// program length is written through cfg, which is always ready; cfg is to be
// written only while the block is idle, and the block does not enforce this.
// An accepted instruction reads its operands from the register file RAM at
// the accepting edge, executes in the following cycle and is captured in the
// result register once that register is free. One instruction is taken per
// cycle unless the result is stalled or a dump runs, set by the single
// execute stage and the one RAM write port. HLT dumps the registers from
// the execute stage, one per cycle through RAM port a while the result is
// not stalled, and gives five results, the last one marked.
// Reset clears the register-file valid bits, so all registers read as zero,
// sets the program counter to one and the program length to 256. No
// clearing pass is needed.
// When the receiver stalls, the result register holds, the execute stage
// holds its instruction, and instr.ready falls once both are full.
`include "tiny_register_machine_execute_macros.svh"

module tiny_register_machine_execute import trme_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	trme_in_if.sink  instr,
	trme_out_if.source result,
	trme_cfg_if.sink cfg
);

	// Execute stage registers.
	logic                    s1_vld_q;
	logic [FUNC_W-1:0]       func_s1;
	logic [REG_IDX_W-1:0]    first_reg_s1;
	logic                    src_is_reg_s1;
	logic [REG_IDX_W-1:0]    source_reg_s1;
	logic [DATA_WIDTH-1:0]   imm_s1;
	logic [CNT_W-1:0]        cnt_q;

	// Architectural state.
	logic [PC_W-1:0]         pc_q;
	logic [PC_W-1:0]         plen_q;
	logic [NUM_REGS-1:0]     rf_vld_q;

	// Bypass of the write made at the last edge.
	logic                    wr_en_q;
	logic [RF_AW-1:0]        wr_addr_q;
	logic [DATA_WIDTH-1:0]   wr_data_q;

	// Result register.
	logic                    out_vld_q;
	logic [PC_W-1:0]         npc_s2;
	logic                    value_valid_s2;
	logic [DATA_WIDTH-1:0]   value_s2;
	logic [REG_IDX_W-1:0]    value_index_s2;
	logic                    is_halted_s2;
	logic                    status_s2;
	logic                    last_s2;

	// Combinational signals.
	logic                    accept;
	logic                    s1_fire;
	logic                    s1_done;
	logic                    is_hlt;
	logic [RF_AW-1:0]        ra_s1;
	logic [RF_AW-1:0]        rb_s1;
	logic [RF_AW-1:0]        rd_a;
	logic [RF_AW-1:0]        rd_b;
	logic [DATA_WIDTH-1:0]   ram_a;
	logic [DATA_WIDTH-1:0]   ram_b;
	logic [DATA_WIDTH-1:0]   va;
	logic [DATA_WIDTH-1:0]   vb;
	logic                    a_ok;
	logic                    b_ok;
	logic [PC_W-1:0]         eff_len;
	logic [PC_W-1:0]         npc_inc;
	logic [PC_W-1:0]         npc;
	logic                    wr_en;
	logic [RF_AW-1:0]        wr_addr;
	logic [DATA_WIDTH-1:0]   wr_data;
	logic                    x_valid;
	logic [DATA_WIDTH-1:0]   x_value;
	logic [REG_IDX_W-1:0]    x_index;
	logic                    x_status;
	logic                    x_last;
	logic [DATA_WIDTH-1:0]   src;
	logic                    jmp_bad;

	// Handshakes: the execute stage moves on when the result register frees up.
	assign is_hlt    = (func_s1 == FN_HLT);
	assign s1_fire   = s1_vld_q && (!out_vld_q || result.ready);
	assign s1_done   = s1_fire && (!is_hlt || (cnt_q == CNT_W'(NUM_REGS - 1)));
	assign instr.ready = !s1_vld_q || s1_done;
	assign accept    = instr.valid && instr.ready;
	assign cfg.ready = 1'b1;

	// Register addresses of the instruction in the execute stage.
	assign ra_s1 = is_hlt ? RF_AW'(cnt_q) : RF_AW'(first_reg_s1);
	assign rb_s1 = RF_AW'(source_reg_s1);

	// Read addresses for the next cycle: a new instruction, the next dump entry,
	// or a re-read of the held instruction.
	always_comb begin
		if (accept) begin
			rd_a = (instr.func == FN_HLT) ? '0 : RF_AW'(instr.first_reg);
			rd_b = RF_AW'(instr.source_reg);
		end else if (s1_fire && is_hlt) begin
			rd_a = RF_AW'(cnt_q + CNT_W'(1));
			rd_b = rb_s1;
		end else begin
			rd_a = ra_s1;
			rd_b = rb_s1;
		end
	end

	trme_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (NUM_REGS)
	) u_rf (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.raddr_a (rd_a),
		.raddr_b (rd_b),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	// Operands: bypass the write made at the last edge, unwritten entries read zero.
	always_comb begin
		if (wr_en_q && (wr_addr_q == ra_s1)) begin
			va = wr_data_q;
		end else begin
			va = rf_vld_q[ra_s1] ? ram_a : '0;
		end
		if (wr_en_q && (wr_addr_q == rb_s1)) begin
			vb = wr_data_q;
		end else begin
			vb = rf_vld_q[rb_s1] ? ram_b : '0;
		end
	end

	// Program counter increment and clamped program length.
	assign eff_len = (plen_q > PC_W'(PROG_MAX)) ? PC_W'(PROG_MAX) : plen_q;
	assign npc_inc = (pc_q == PC_W'(PROG_MAX + 1)) ? pc_q : pc_q + PC_W'(1);

	assign a_ok    = first_reg_s1 < REG_IDX_W'(NUM_REGS);
	assign b_ok    = source_reg_s1 < REG_IDX_W'(NUM_REGS);
	assign src     = src_is_reg_s1 ? vb : imm_s1;
	assign jmp_bad = imm_s1[DATA_WIDTH-1] || (imm_s1 == '0) ||
		(imm_s1 > DATA_WIDTH'(eff_len));

	// Execute one instruction, or one entry of a register dump.
	always_comb begin
		npc      = npc_inc;
		wr_en    = 1'b0;
		wr_addr  = RF_AW'(first_reg_s1);
		wr_data  = '0;
		x_valid  = 1'b0;
		x_value  = '0;
		x_index  = '0;
		x_status = 1'b0;
		x_last   = 1'b1;
		case (func_t'(func_s1))
			FN_MOV: begin
				if (a_ok && (!src_is_reg_s1 || b_ok)) begin
					wr_en = 1'b1;
					if (src_is_reg_s1) begin
						wr_addr = rb_s1;
						wr_data = va;
					end else begin
						wr_data = imm_s1;
					end
				end
			end
			FN_ADD: begin
				wr_en   = a_ok && (!src_is_reg_s1 || b_ok);
				wr_data = va + src;
			end
			FN_SUB: begin
				wr_en   = a_ok && (!src_is_reg_s1 || b_ok);
				wr_data = va - src;
			end
			FN_JMP: begin
				if (jmp_bad) begin
					x_status = 1'b1;
				end else if (!src_is_reg_s1 || (a_ok && (va == '0))) begin
					npc = PC_W'(imm_s1);
				end
			end
			FN_PRN: begin
				if (src_is_reg_s1) begin
					if (b_ok) begin
						x_valid = 1'b1;
						x_value = vb;
						x_index = source_reg_s1;
					end
				end else begin
					x_valid = 1'b1;
					x_value = imm_s1;
					x_index = REG_IDX_W'(CONST_INDEX);
				end
			end
			FN_HLT: begin
				x_valid = 1'b1;
				x_value = va;
				x_index = REG_IDX_W'(cnt_q);
				x_last  = (cnt_q == CNT_W'(NUM_REGS - 1));
			end
			default: begin
			end
		endcase
		wr_en = wr_en && s1_fire;
	end

	// Control state: stage occupancy, dump counter, program counter, valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			cnt_q     <= '0;
			pc_q      <= PC_W'(1);
			plen_q    <= PC_W'(PROG_MAX);
			rf_vld_q  <= '0;
			wr_en_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_vld_q <= 1'b1;
				cnt_q    <= '0;
			end else if (s1_done) begin
				s1_vld_q <= 1'b0;
			end else if (s1_fire && is_hlt) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (s1_done) begin
				pc_q <= npc;
			end
			if (cfg.valid) begin
				plen_q <= cfg.data;
			end
			if (wr_en) begin
				rf_vld_q[wr_addr] <= 1'b1;
			end
			wr_en_q <= wr_en;
			if (s1_fire) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers of the execute stage, bypass and result.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1       <= instr.func;
			first_reg_s1  <= instr.first_reg;
			src_is_reg_s1 <= instr.src_is_reg;
			source_reg_s1 <= instr.source_reg;
			imm_s1        <= instr.immediate;
		end
		wr_addr_q <= wr_addr;
		wr_data_q <= wr_data;
		if (s1_fire) begin
			npc_s2         <= npc;
			value_valid_s2 <= x_valid;
			value_s2       <= x_value;
			value_index_s2 <= x_index;
			is_halted_s2   <= (npc >= eff_len);
			status_s2      <= x_status;
			last_s2        <= x_last;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.next_pc     = npc_s2;
	assign result.value_valid = value_valid_s2;
	assign result.value       = value_s2;
	assign result.value_index = value_index_s2;
	assign result.is_halted   = is_halted_s2;
	assign result.status      = status_s2;
	assign result.last        = last_s2;

	// Consistency checks on the execute stage and the result register.
	`TRME_CHECK(a_cnt_range, cnt_q < CNT_W'(NUM_REGS), "dump counter out of range")
	`TRME_CHECK(a_pc_range, pc_q <= PC_W'(PROG_MAX + 1), "program counter beyond saturation")
	`TRME_IMPLIES(a_dump_blocks, s1_vld_q && is_hlt && (cnt_q != CNT_W'(NUM_REGS - 1)), !instr.ready, "new request taken during register dump")
	`TRME_IMPLIES(a_only_dump_not_last, out_vld_q && !last_s2, value_valid_s2 && (value_index_s2 < REG_IDX_W'(NUM_REGS)), "non-final result is not a register dump entry")
	`TRME_IMPLIES(a_error_no_value, out_vld_q && status_s2, !value_valid_s2, "jump error carries a value")

endmodule
